// ===== hdl/bdc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the business day counter.
// Holds the command and result words and the calendar helper functions; no dependencies.
package bdc_pkg;

	localparam int DAY_W   = 5;
	localparam int MONTH_W = 4;
	localparam int YEAR_W  = 14;
	localparam int COUNT_W = 22;
	localparam int MASK_W  = 7;

	localparam logic [MASK_W-1:0]  MASK_RESET = 7'd96;
	localparam logic [COUNT_W-1:0] COUNT_MAX  = 22'd4194303;

	// Month codes used by the calendar logic
	localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
	localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;
	localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

	// Weekday codes, Sunday first
	localparam logic [2:0] WD_SUNDAY   = 3'd0;
	localparam logic [2:0] WD_SATURDAY = 3'd6;

	typedef struct packed {
		logic [DAY_W-1:0]   start_day;
		logic [MONTH_W-1:0] start_month;
		logic [YEAR_W-1:0]  start_year;
		logic [DAY_W-1:0]   end_day;
		logic [MONTH_W-1:0] end_month;
		logic [YEAR_W-1:0]  end_year;
	} cmd_t;

	typedef struct packed {
		logic [COUNT_W-1:0] working_days;
		logic               bad_date;
	} result_t;

	// Length of a month; zero for a month code out of range
	function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
		input logic leap);
		logic [DAY_W-1:0] len;
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                      len = 5'd30;
			4'd2:                                         len = leap ? 5'd29 : 5'd28;
			default:                                      len = 5'd0;
		endcase
		return len;
	endfunction

	// Month term of the weekday formula (January first)
	function automatic logic [2:0] month_term(input logic [MONTH_W-1:0] m);
		logic [2:0] t;
		case (m)
			4'd1:    t = 3'd0;
			4'd2:    t = 3'd3;
			4'd3:    t = 3'd2;
			4'd4:    t = 3'd5;
			4'd5:    t = 3'd0;
			4'd6:    t = 3'd3;
			4'd7:    t = 3'd5;
			4'd8:    t = 3'd1;
			4'd9:    t = 3'd4;
			4'd10:   t = 3'd6;
			4'd11:   t = 3'd2;
			4'd12:   t = 3'd4;
			default: t = 3'd0;
		endcase
		return t;
	endfunction

	// Residue modulo 7 by folding octal digits, since 8 is 1 modulo 7
	function automatic logic [2:0] mod7(input logic [15:0] x);
		logic [5:0] a;
		logic [3:0] b;
		a = 6'(x[15]) + 6'(x[14:12]) + 6'(x[11:9]) + 6'(x[8:6]) + 6'(x[5:3])
			+ 6'(x[2:0]);
		b = 4'(a[5:3]) + 4'(a[2:0]);
		if (b >= 4'd7) begin
			b = b - 4'd7;
		end
		return b[2:0];
	endfunction

	// Gregorian leap test from the low year bits and the year modulo 400
	function automatic logic is_leap(input logic [1:0] y_lo, input logic [8:0] r400);
		return (y_lo == 2'd0) && !((r400 == 9'd100) || (r400 == 9'd200) ||
			(r400 == 9'd300));
	endfunction

endpackage

// ===== hdl/business_day_counter_top.sv =====
`timescale 1ns / 1ps
// Business day counter: counts unmasked weekdays from a start date up to an end date.
// Steps: year unit passes for the end year, the start year and the weekday sum, a check
// that ends an invalid or empty span, then the calendar walk, one day a cycle. One word
// at a time: busy stays high until the result strobe, high for one cycle and cannot be
// stalled. Reset (arst_n low, asynchronous) returns to idle and loads the weekend mask
// with Friday and Saturday. Depends on bdc_pkg.
module business_day_counter_top
	import bdc_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	// command channel
	input  logic          start,
	output logic          busy,
	input  cmd_t          cmd,
	// result channel
	output logic          done,
	output result_t       result,
	// configuration port
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [2:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready
);

	// Sequencer codes
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_DIV   = 3'd1;
	localparam logic [2:0] ST_REM   = 3'd2;
	localparam logic [2:0] ST_CHECK = 3'd3;
	localparam logic [2:0] ST_WALK  = 3'd4;

	// Operand selects of the shared year unit
	localparam logic [1:0] SEL_END   = 2'd0;
	localparam logic [1:0] SEL_START = 2'd1;
	localparam logic [1:0] SEL_WDAY  = 2'd2;

	// Register index decode
	localparam logic REG_MASK = 1'b0;

	localparam logic [12:0] RECIP_25 = 13'd5243;  // 2^17 / 25, rounded up

	logic [2:0]        state_q;
	logic [1:0]        sel_q;
	logic [MASK_W-1:0] mask_q;
	logic              done_q;
	result_t           result_q;
	cmd_t              cmd_q;

	// shared year unit
	logic [14:0]  operand;
	logic [25:0]  prod;
	logic [7:0]   q100_q;
	logic [5:0]   q400;
	logic [8:0]   r400;
	logic [8:0]   end_r400_q;
	logic [8:0]   start_r400_q;
	logic [15:0]  wsum_q;
	logic [14:0]  yy;

	// calendar walk
	logic [DAY_W-1:0]   wday_q;
	logic [MONTH_W-1:0] wmon_q;
	logic [YEAR_W-1:0]  wyear_q;
	logic [8:0]         wr400_q;
	logic [2:0]         wdow_q;
	logic [COUNT_W-1:0] tally_q;
	logic               wleap;
	logic [DAY_W-1:0]   wlen;
	logic               at_end;

	logic accept;
	logic cfg_write;
	logic start_ok;
	logic end_ok;
	logic in_order;

	assign accept    = start && !busy;
	assign busy      = (state_q != ST_IDLE);
	assign done      = done_q;
	assign result    = result_q;
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite;

	// Read back the mask wherever paddr[2] is low, zero elsewhere
	assign prdata = (paddr[2] == REG_MASK) ? {25'd0, mask_q} : 32'd0;

	// Shift the year back one for January and February so the leap day ends the year
	assign yy = 15'(cmd_q.start_year) + 15'd400 -
		((cmd_q.start_month < MONTH_MAR) ? 15'd1 : 15'd0);

	always_comb begin
		case (sel_q)
			SEL_END:   operand = 15'(cmd_q.end_year);
			SEL_START: operand = 15'(cmd_q.start_year);
			default:   operand = yy;
		endcase
	end

	// Year / 100 as (year / 4) / 25 through the reciprocal; year / 400 follows by a shift
	assign prod = 26'(operand[14:2]) * 26'(RECIP_25);
	assign q400 = q100_q[7:2];
	assign r400 = 9'(operand - ((15'(q400) << 8) + (15'(q400) << 7) + (15'(q400) << 4)));

	// Validity of both dates and ordering, once the leap status of both years is known
	assign start_ok = (cmd_q.start_day != 5'd0) && (cmd_q.start_day <=
		month_days(cmd_q.start_month, is_leap(cmd_q.start_year[1:0], start_r400_q)));
	assign end_ok = (cmd_q.end_day != 5'd0) && (cmd_q.end_day <=
		month_days(cmd_q.end_month, is_leap(cmd_q.end_year[1:0], end_r400_q)));
	assign in_order = {cmd_q.start_year, cmd_q.start_month, cmd_q.start_day} <
		{cmd_q.end_year, cmd_q.end_month, cmd_q.end_day};

	assign wleap  = is_leap(wyear_q[1:0], wr400_q);
	assign wlen   = month_days(wmon_q, wleap);
	assign at_end = ({wyear_q, wmon_q, wday_q} ==
		{cmd_q.end_year, cmd_q.end_month, cmd_q.end_day});

	// Control: sequencer, mask register and the result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sel_q   <= SEL_END;
			done_q  <= 1'b0;
			mask_q  <= MASK_RESET;
		end else begin
			done_q <= 1'b0;
			if (cfg_write && (paddr[2] == REG_MASK)) begin
				mask_q <= pwdata[MASK_W-1:0];
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_DIV;
						sel_q   <= SEL_END;
					end
				end
				ST_DIV: begin
					state_q <= ST_REM;
				end
				ST_REM: begin
					if (sel_q == SEL_WDAY) begin
						state_q <= ST_CHECK;
					end else begin
						state_q <= ST_DIV;
						sel_q   <= sel_q + 2'd1;
					end
				end
				ST_CHECK: begin
					if (!start_ok || !end_ok || !in_order) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end else begin
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (at_end) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath: operands, year unit results, walk registers and the result word
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd;
		end
		case (state_q)
			ST_DIV: begin
				q100_q <= prod[24:17];
			end
			ST_REM: begin
				case (sel_q)
					SEL_END:   end_r400_q   <= r400;
					SEL_START: start_r400_q <= r400;
					default: begin
						wsum_q <= 16'(yy) + 16'(yy[14:2]) - 16'(q100_q) + 16'(q400) +
							16'(month_term(cmd_q.start_month)) + 16'(cmd_q.start_day);
					end
				endcase
			end
			ST_CHECK: begin
				// Load the walk at the start date; drop straight to the result if nothing to walk
				wday_q   <= cmd_q.start_day;
				wmon_q   <= cmd_q.start_month;
				wyear_q  <= cmd_q.start_year;
				wr400_q  <= start_r400_q;
				wdow_q   <= mod7(wsum_q);
				tally_q  <= '0;
				result_q.working_days <= '0;
				result_q.bad_date     <= !start_ok || !end_ok;
			end
			ST_WALK: begin
				if (at_end) begin
					result_q.working_days <= tally_q;
					result_q.bad_date     <= 1'b0;
				end else begin
					// Count today if its weekday is unmasked, holding at the ceiling
					if (!mask_q[wdow_q] && (tally_q != COUNT_MAX)) begin
						tally_q <= tally_q + 22'd1;
					end
					wdow_q <= (wdow_q == WD_SATURDAY) ? WD_SUNDAY : wdow_q + 3'd1;
					// Advance one day, rolling over month and year
					if (wday_q == wlen) begin
						wday_q <= 5'd1;
						if (wmon_q == MONTH_DEC) begin
							wmon_q  <= 4'd1;
							wyear_q <= wyear_q + 14'd1;
							wr400_q <= (wr400_q == 9'd399) ? 9'd0 : wr400_q + 9'd1;
						end else begin
							wmon_q <= wmon_q + 4'd1;
						end
					end else begin
						wday_q <= wday_q + 5'd1;
					end
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== hdl/bdc_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the business day counter, bound to the top level.
// Depends on bdc_pkg and business_day_counter_top.
module bdc_checker
	import bdc_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    start,
	input logic    busy,
	input logic    done,
	input result_t result
);

	// The result strobe ends the job, so the block is free in that cycle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// An accepted word holds the block busy in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted word did not raise busy");

	// No result can follow its word in the very next cycle
	a_accept_no_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> !done)
		else $error("result strobe directly after accept");

	// A bad date always carries a zero count
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.bad_date) |-> (result.working_days == '0))
		else $error("bad date with non-zero count");

endmodule

bind business_day_counter_top bdc_checker u_bdc_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);
